@@ rtl/epsc_pkg.sv @@
// ----------------------------------------------------------------------------
// epsc_pkg
// shared types and constants for the encoder pid speed controller
// ----------------------------------------------------------------------------
package epsc_pkg;

  localparam logic [1:0] CMD_EDGE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_STOP = 2'd2;

  localparam logic [2:0] REG_TARGET = 3'd0;
  localparam logic [2:0] REG_GAIN_P = 3'd1;
  localparam logic [2:0] REG_GAIN_I = 3'd2;
  localparam logic [2:0] REG_GAIN_D = 3'd3;
  localparam logic [2:0] REG_BASE   = 3'd4;
  localparam logic [2:0] REG_CPR    = 3'd5;
  localparam logic [2:0] REG_ILIM   = 3'd6;

  localparam logic [23:0] SPEED_MAX = 24'hFFFFFF;
  localparam logic [15:0] RPM_SCALE = 16'd60000;

  // unsigned restoring divider job: quotient bits produced one per cycle
  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [47:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/epsc_div.sv @@
// ----------------------------------------------------------------------------
// epsc_div
// bit-serial restoring divider, saturating quotient to 24 bits
// ----------------------------------------------------------------------------
module epsc_div (
  input  logic               clk,
  input  logic               rst,
  input  epsc_pkg::div_req_t req,
  output epsc_pkg::div_rsp_t rsp
);

  logic [63:0] rem;
  logic [63:0] quo;
  logic [47:0] den;
  logic [6:0]  cnt;
  logic        busy;
  logic        done;
  logic [64:0] trial;
  logic [63:0] shifted;
  logic [23:0] quot_sat;

  // shift in next numerator bit (stored in quo, msb first)
  assign shifted = {rem[62:0], quo[63]};
  assign trial   = {1'b0, shifted} - {17'd0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
        cnt  <= 7'd0;
      end else if (busy) begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate; zero divisor gives all ones
  always_comb begin
    if (den == '0 || quo[63:24] != '0) quot_sat = epsc_pkg::SPEED_MAX;
    else quot_sat = quo[23:0];
  end

  assign rsp = {done, quot_sat};

endmodule

@@ rtl/epsc_mul.sv @@
// ----------------------------------------------------------------------------
// epsc_mul
// bit-serial shift-add signed multiplier, 16-bit signed by 40-bit signed
// ----------------------------------------------------------------------------
module epsc_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] a,
  input  logic signed [39:0] b,
  output logic               done,
  output logic signed [55:0] prod
);

  logic signed [55:0] acc;
  logic signed [55:0] mcand;
  logic [15:0]        mplier;
  logic [4:0]         cnt;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= 56'(b);
        mplier <= a;
        cnt    <= 5'd0;
      end else if (busy) begin
        // top bit of a two's complement multiplier carries negative weight
        if (mplier[0]) begin
          if (cnt == 5'd15) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

@@ rtl/encoder_pid_speed_controller_unit.sv @@
// ----------------------------------------------------------------------------
// encoder_pid_speed_controller_unit
// encoder counter, speed measurement and pid duty computation
// ----------------------------------------------------------------------------
// usage
// - s_axis carries one transaction per command: tdata holds command, chan_a,
//   chan_b and elapsed_ms from the low bit up, padded to 24 bits
// - an edge transaction moves the position counter with no result; ready stays
//   high, so edges can follow one per cycle while no result waits at the output
// - a stop transaction gives duty 0 in coast mode and the held speed; the
//   result is shown from the output state
// - a tick transaction measures the speed with a bit-serial 64-step divider,
//   then two 36-step serial divides (integral step, derivative) and three
//   16-step serial gain multiplies before the sum and output states; a tick
//   with elapsed_ms of zero skips the divider and uses the held speed
// - one item is worked at a time; s_axis_tready is low while a tick or stop
//   is in flight or while a finished result waits in the output register
// - m_axis holds its result until taken; a stall simply holds off the next
//   transaction on the input side
// - the apb port writes and reads the seven control registers at 4*index;
//   writes are intended while the block is idle
// - synchronous reset restores register defaults and clears the controller state
// ----------------------------------------------------------------------------
module encoder_pid_speed_controller_unit #(
  parameter int CONTROL_PERIOD_MS = 100,
  parameter int COUNT_BITS        = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command[1:0], chan_a, chan_b, elapsed_ms[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // duty[7:0], drive_mode, measured_speed[23:0],
                                     // speed_error[24:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PERIOD_W = $clog2(CONTROL_PERIOD_MS + 1);
  localparam logic [PERIOD_W-1:0] PERIOD = PERIOD_W'(CONTROL_PERIOD_MS);
  localparam logic [9:0] MS_PER_S = 10'd1000;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_ERR  = 8'b0000_0100,
    ST_IDIV = 8'b0000_1000,
    ST_DDIV = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_SUM  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_t;

  state_t state;

  // control registers
  logic [23:0]        target_speed;
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [7:0]         base_duty;
  logic [15:0]        counts_per_rev;
  logic [14:0]        integral_limit;

  // controller state
  logic [COUNT_BITS-1:0] pulse_count, count_at_last_tick;
  logic [23:0]           speed_reg;
  logic signed [15:0]    integral_sum;
  logic signed [25:0]    last_error;

  logic [1:0]  command;
  logic        chan_a, chan_b;
  logic [15:0] elapsed_ms;
  assign command    = s_axis_tdata[1:0];
  assign chan_a     = s_axis_tdata[2];
  assign chan_b     = s_axis_tdata[3];
  assign elapsed_ms = s_axis_tdata[19:4];

  logic in_acc, out_acc, cfg_wr, tgt_wr;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  // nonzero target write also clears the integral and the last error
  assign tgt_wr  = cfg_wr && paddr[1:0] == 2'b00 && paddr[4:2] == epsc_pkg::REG_TARGET
                   && pwdata[23:0] != '0;

  // apb register file
  always_ff @(posedge clk) begin
    if (rst) begin
      target_speed   <= 24'd25600;
      gain_p         <= 16'sd512;
      gain_i         <= 16'sd128;
      gain_d         <= 16'sd26;
      base_duty      <= 8'd80;
      counts_per_rev <= 16'd330;
      integral_limit <= 15'd25600;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      case (paddr[4:2])
        epsc_pkg::REG_TARGET: if (pwdata[23:0] != '0) target_speed <= pwdata[23:0];
        epsc_pkg::REG_GAIN_P: gain_p <= pwdata[15:0];
        epsc_pkg::REG_GAIN_I: gain_i <= pwdata[15:0];
        epsc_pkg::REG_GAIN_D: gain_d <= pwdata[15:0];
        epsc_pkg::REG_BASE:   base_duty <= pwdata[7:0];
        epsc_pkg::REG_CPR:    counts_per_rev <= pwdata[15:0];
        epsc_pkg::REG_ILIM:   integral_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      epsc_pkg::REG_TARGET: prdata = {8'd0, target_speed};
      epsc_pkg::REG_GAIN_P: prdata = {{16{gain_p[15]}}, gain_p};
      epsc_pkg::REG_GAIN_I: prdata = {{16{gain_i[15]}}, gain_i};
      epsc_pkg::REG_GAIN_D: prdata = {{16{gain_d[15]}}, gain_d};
      epsc_pkg::REG_BASE:   prdata = {24'd0, base_duty};
      epsc_pkg::REG_CPR:    prdata = {16'd0, counts_per_rev};
      epsc_pkg::REG_ILIM:   prdata = {17'd0, integral_limit};
      default:              prdata = '0;
    endcase
  end

  // speed divider
  epsc_pkg::div_req_t div_req;
  epsc_pkg::div_rsp_t div_rsp;
  epsc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  // count delta magnitude; the most negative delta keeps its own pattern
  logic [COUNT_BITS-1:0] delta, mag;
  assign delta = pulse_count - count_at_last_tick;
  assign mag   = delta[COUNT_BITS-1] ? (~delta + 1'b1) : delta;

  // numerator = mag * 60000 * 256 built with shifts, one 32x16 product
  logic [47:0] mag_scaled;
  assign mag_scaled = 48'(mag) * 48'(epsc_pkg::RPM_SCALE);

  // denominator = counts_per_rev * elapsed_ms of the accepted tick
  logic [31:0] den_prod;
  assign den_prod = 32'(counts_per_rev) * 32'(elapsed_ms);

  // serial divide for the integral step and the derivative
  logic [35:0] sd_rem, sd_quo;
  logic [5:0]  sd_cnt;
  logic [36:0] sd_trial;
  logic [35:0] sd_shift;
  logic [35:0] sd_q_final;
  logic [15:0] sd_den;
  assign sd_shift   = {sd_rem[34:0], sd_quo[35]};
  assign sd_trial   = {1'b0, sd_shift} - {21'd0, sd_den};
  assign sd_q_final = {sd_quo[34:0], !sd_trial[36]};

  logic signed [25:0] err;
  logic signed [25:0] e_now;
  logic [25:0]        e_mag;
  logic signed [26:0] diff;
  logic [26:0]        diff_mag;
  logic               neg;
  logic signed [31:0] integ_step;
  logic signed [39:0] deriv;
  logic signed [31:0] integ;
  logic signed [31:0] integ_sum32;
  logic signed [15:0] lim_s;

  assign e_now    = 26'(target_speed) - 26'(speed_reg);
  assign e_mag    = e_now[25] ? 26'(-e_now) : e_now;
  assign diff     = 27'(err) - 27'(last_error);
  assign diff_mag = diff[26] ? 27'(-diff) : diff;

  // multiplier shared over three terms
  logic               mul_start, mul_done;
  logic signed [15:0] mul_a;
  logic signed [39:0] mul_b;
  logic signed [55:0] mul_prod;
  logic [1:0]         term;
  logic signed [57:0] total;
  epsc_mul u_mul (.clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
                  .done(mul_done), .prod(mul_prod));

  assign lim_s       = {1'b0, integral_limit};
  assign integ_sum32 = 32'(integral_sum) + integ_step;

  always_comb begin
    case (term)
      2'd0:    begin mul_a = gain_p; mul_b = 40'(err);   end
      2'd1:    begin mul_a = gain_i; mul_b = 40'(integ); end
      default: begin mul_a = gain_d; mul_b = deriv;      end
    endcase
  end

  logic [7:0]  duty_o;
  logic [24:0] err_o;
  logic        mode_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      pulse_count        <= '0;
      count_at_last_tick <= '0;
      speed_reg          <= '0;
      integral_sum       <= '0;
      last_error         <= '0;
      m_axis_tvalid      <= 1'b0;
      div_req.start      <= 1'b0;
      mul_start          <= 1'b0;
    end else begin
      div_req.start <= 1'b0;
      mul_start     <= 1'b0;
      if (out_acc) m_axis_tvalid <= 1'b0;
      if (tgt_wr) begin
        integral_sum <= '0;
        last_error   <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (command)
              epsc_pkg::CMD_EDGE: begin
                if (chan_a == chan_b) pulse_count <= pulse_count + 1'b1;
                else pulse_count <= pulse_count - 1'b1;
              end
              epsc_pkg::CMD_STOP: begin
                duty_o <= '0;
                mode_o <= 1'b0;
                err_o  <= '0;
                state  <= ST_OUT;
              end
              epsc_pkg::CMD_TICK: begin
                if (elapsed_ms != '0) begin
                  count_at_last_tick <= pulse_count;
                  div_req.num        <= {mag_scaled, 16'd0} >> 8;
                  div_req.den        <= 48'(den_prod);
                  div_req.start      <= 1'b1;
                  state              <= ST_DIV;
                end else begin
                  state <= ST_ERR;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            speed_reg <= div_rsp.quot;
            state     <= ST_ERR;
          end
        end
        ST_ERR: begin
          // integral step magnitude: |e| * period, divided by 1000 serially
          err    <= e_now;
          neg    <= e_now[25];
          sd_quo <= 36'(e_mag) * 36'(CONTROL_PERIOD_MS);
          sd_rem <= '0;
          sd_den <= 16'(MS_PER_S);
          sd_cnt <= '0;
          state  <= ST_IDIV;
        end
        ST_IDIV, ST_DDIV: begin
          if (!sd_trial[36]) begin
            sd_rem <= sd_trial[35:0];
            sd_quo <= {sd_quo[34:0], 1'b1};
          end else begin
            sd_rem <= sd_shift;
            sd_quo <= {sd_quo[34:0], 1'b0};
          end
          sd_cnt <= sd_cnt + 6'd1;
          if (sd_cnt == 6'd35) begin
            sd_cnt <= '0;
            if (state == ST_IDIV) begin
              integ_step <= neg ? -32'(sd_q_final) : 32'(sd_q_final);
              // derivative: |e - last| * 1000 / period
              neg    <= diff[26];
              sd_quo <= 36'(diff_mag) * 36'(MS_PER_S);
              sd_rem <= '0;
              sd_den <= 16'(PERIOD);
              state  <= ST_DDIV;
            end else begin
              deriv <= neg ? -40'(sd_q_final) : 40'(sd_q_final);
              if (integ_sum32 > 32'(lim_s)) integ <= 32'(lim_s);
              else if (integ_sum32 < -32'(lim_s)) integ <= -32'(lim_s);
              else integ <= integ_sum32;
              total     <= 58'(base_duty) <<< 16;
              term      <= 2'd0;
              mul_start <= 1'b1;
              state     <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            total <= total + 58'(mul_prod);
            if (term == 2'd2) begin
              state <= ST_SUM;
            end else begin
              term      <= term + 2'd1;
              mul_start <= 1'b1;
            end
          end
        end
        ST_SUM: begin
          integral_sum <= integ[15:0];
          last_error   <= err;
          mode_o       <= 1'b1;
          err_o        <= err[24:0];
          if (total <= 0) duty_o <= '0;
          else if (total[57:16] > 42'd255) duty_o <= 8'd255;
          else duty_o <= total[23:16];
          state <= ST_OUT;
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {6'd0, err_o, speed_reg, mode_o, duty_o};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");
  a_busy_noready: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !s_axis_tready)
    else $error("ready while busy");
  a_stop_coast: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !mode_o |-> duty_o == '0)
    else $error("coast with nonzero duty");

endmodule
